### hw/rtl/iambic_keyer_recorder_assert.svh
// assertion helpers for the keyer recorder
`ifndef IAMBIC_KEYER_RECORDER_ASSERT_SVH
`define IAMBIC_KEYER_RECORDER_ASSERT_SVH

// clocked check, muted while reset is held
`define IKR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define IKR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### hw/rtl/ikr_pkg.sv
package ikr_pkg;

    // keyer phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_MARK   = 2'd1,
        PH_GAP    = 2'd2,
        PH_DECIDE = 2'd3
    } t_phase;

    localparam logic [7:0] CODE_DIT  = 8'd1;
    localparam logic [7:0] CODE_DAH  = 8'd3;
    localparam logic       SPACE_TAG = 1'b1;
    localparam logic [6:0] SPACE_MAX = 7'h7F;

    // units left in the mark after its first tick
    localparam logic [1:0] DAH_LEFT = 2'd2;

    // keyer and recorder state
    typedef struct packed {
        t_phase     phase;
        logic [1:0] units_left;
        logic       cur_dah;
        logic [6:0] space_units;
        logic       space_counting;
        logic       iambic;
    } t_state;

    // one result request
    typedef struct packed {
        logic       sidetone_on;
        logic       record_valid;
        logic [7:0] record_code;
        logic       iambic_active;
    } t_result;

endpackage

### hw/rtl/iambic_keyer_recorder.sv
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+----------------------------------------
// paddles   | in        | i_in_valid / o_in_stall  | i_paddle_a_pressed, i_paddle_b_pressed
// result    | out       | o_out_valid / i_out_stall| o_sidetone_on, o_record_valid,
//           |           |                          | o_record_code, o_iambic_active
// config    | in        | i_cfg_we                 | i_cfg_wdata (swap_paddles)
//
// one request per clock while no stall holds the flow; the result passes through the
// input register, then one pass of the keyer step into the result register
// keyer state advances as the input register hands its request to the result register
// synchronous active-low reset clears the keyer state, config and both valid flags
// an output stall holds the result register and backs up into the input register
module iambic_keyer_recorder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_paddle_a_pressed,
    input  logic       i_paddle_b_pressed,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_sidetone_on,
    output logic       o_record_valid,
    output logic [7:0] o_record_code,
    output logic       o_iambic_active
);

    logic             r_in_vld;
    logic             r_pad_a;
    logic             r_pad_b;
    logic             r_swap;
    logic             r_out_vld;
    ikr_pkg::t_state  r_state;
    ikr_pkg::t_state  n_state;
    ikr_pkg::t_result r_result;
    ikr_pkg::t_result n_result;
    logic             w_out_free;
    logic             w_in_free;
    logic             w_move;
    logic             w_rec_out;
    logic             w_quiet_out;
    logic             w_code_ok;
    logic             w_gap_move;
    logic             w_mark_now;

    // pipeline flow
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_in_free  = !r_in_vld || w_out_free;
    assign w_move     = r_in_vld && w_out_free;
    assign o_in_stall = !w_in_free;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap <= 1'b0;
        end else if (i_cfg_we) begin
            r_swap <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_free) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_in_free) begin
            r_pad_a <= i_paddle_a_pressed;
            r_pad_b <= i_paddle_b_pressed;
        end
    end

    // keyer step
    ikr_step u_step (
        .i_state    (r_state),
        .i_paddle_a (r_pad_a),
        .i_paddle_b (r_pad_b),
        .i_swap     (r_swap),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    // keyer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: ikr_pkg::PH_IDLE, default: '0};
        end else if (w_move) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_sidetone_on   = r_result.sidetone_on;
    assign o_record_valid  = r_result.record_valid;
    assign o_record_code   = r_result.record_code;
    assign o_iambic_active = r_result.iambic_active;

    // check terms
    assign w_rec_out   = r_out_vld && o_record_valid;
    assign w_quiet_out = r_out_vld && !o_record_valid;
    assign w_code_ok   = (o_record_code == ikr_pkg::CODE_DIT) ||
                         (o_record_code == ikr_pkg::CODE_DAH) || o_record_code[7];
    assign w_gap_move  = (r_state.phase == ikr_pkg::PH_GAP) && w_move;
    assign w_mark_now  = (r_state.phase == ikr_pkg::PH_MARK);

    // checks
    `include "iambic_keyer_recorder_assert.svh"

    `IKR_ASSERT(a_code_legal, w_rec_out |-> w_code_ok, "record code is not dit, dah or space")
    `IKR_ASSERT(a_code_quiet, w_quiet_out |-> (o_record_code == 8'd0), "code without record valid")
    `IKR_ASSERT(a_gap_records, w_gap_move |=> w_rec_out, "gap tick did not record its element")
    `IKR_ASSERT_ALWAYS(a_mark_units, w_mark_now |-> (r_state.units_left != 2'd0), "mark with no units")

endmodule

### hw/rtl/ikr_step.sv
module ikr_step (
    input  ikr_pkg::t_state  i_state,
    input  logic             i_paddle_a,
    input  logic             i_paddle_b,
    input  logic             i_swap,
    output ikr_pkg::t_state  o_state,
    output ikr_pkg::t_result o_result
);

    logic       w_dit;
    logic       w_dah;
    logic       w_press;
    logic       w_release;
    logic       w_idle_tick;
    logic       w_start;
    logic       w_new_dah;
    logic       w_new_iambic;
    logic       w_cnt_eff;
    logic [6:0] w_spaces_eff;

    // paddle roles
    assign w_dit   = i_swap ? i_paddle_b : i_paddle_a;
    assign w_dah   = i_swap ? i_paddle_a : i_paddle_b;
    assign w_press = w_dit | w_dah;
    assign w_release = i_state.cur_dah ? !w_dah : !w_dit;

    // shared decisions for this tick
    always_comb begin
        w_idle_tick  = 1'b0;
        w_start      = 1'b0;
        w_new_dah    = 1'b0;
        w_new_iambic = i_state.iambic;
        w_cnt_eff    = i_state.space_counting;
        w_spaces_eff = i_state.space_units;
        case (i_state.phase)
            ikr_pkg::PH_MARK: begin
                w_idle_tick = 1'b0;
            end
            ikr_pkg::PH_GAP: begin
                w_idle_tick = 1'b0;
            end
            ikr_pkg::PH_DECIDE: begin
                if (w_release) begin
                    w_idle_tick  = 1'b1;
                    w_cnt_eff    = 1'b1;
                    w_spaces_eff = '0;
                end else begin
                    w_start      = 1'b1;
                    w_new_iambic = w_dit & w_dah;
                    w_new_dah    = (w_dit & w_dah) ? !i_state.cur_dah : w_dah;
                end
            end
            default: begin
                w_idle_tick = 1'b1;
            end
        endcase
        // a press on an idle tick starts an element
        if (w_idle_tick && w_press) begin
            w_start      = 1'b1;
            w_new_iambic = w_dit & w_dah;
            w_new_dah    = !w_dit;
        end
    end

    // next state
    always_comb begin
        o_state = i_state;
        o_state.space_counting = w_cnt_eff;
        o_state.space_units    = w_spaces_eff;
        o_state.iambic         = w_new_iambic;
        if (w_start) begin
            // element begins and its first mark tick runs now
            o_state.cur_dah    = w_new_dah;
            o_state.units_left = w_new_dah ? ikr_pkg::DAH_LEFT : 2'd0;
            o_state.phase      = w_new_dah ? ikr_pkg::PH_MARK : ikr_pkg::PH_GAP;
            if (w_idle_tick) begin
                o_state.space_units = '0;
            end
        end else if (w_idle_tick) begin
            o_state.phase = ikr_pkg::PH_IDLE;
            if (w_cnt_eff && (w_spaces_eff != ikr_pkg::SPACE_MAX)) begin
                o_state.space_units = w_spaces_eff + 7'd1;
            end
        end else begin
            case (i_state.phase)
                ikr_pkg::PH_MARK: begin
                    if (i_state.units_left <= 2'd1) begin
                        o_state.units_left = 2'd0;
                        o_state.phase      = ikr_pkg::PH_GAP;
                    end else begin
                        o_state.units_left = i_state.units_left - 2'd1;
                    end
                end
                ikr_pkg::PH_GAP: begin
                    o_state.phase = ikr_pkg::PH_DECIDE;
                end
                default: begin
                    o_state.phase = i_state.phase;
                end
            endcase
        end
    end

    // result fields
    always_comb begin
        o_result = '0;
        o_result.iambic_active = w_new_iambic;
        o_result.sidetone_on   = w_start || (i_state.phase == ikr_pkg::PH_MARK);
        if (i_state.phase == ikr_pkg::PH_GAP) begin
            o_result.record_valid = 1'b1;
            o_result.record_code  = i_state.cur_dah ? ikr_pkg::CODE_DAH
                                                    : ikr_pkg::CODE_DIT;
        end else if (w_idle_tick && w_press && w_cnt_eff) begin
            o_result.record_valid = 1'b1;
            o_result.record_code  = {ikr_pkg::SPACE_TAG, w_spaces_eff};
        end
    end

endmodule

### tb/sv/iambic_keyer_recorder_test.sv
module iambic_keyer_recorder_test;
    import ikr_pkg::*;

    localparam int LONG_HOLD   = 60;
    localparam int CYCLE_LIMIT = 250000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       paddle_a;
    logic       paddle_b;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       out_valid;
    logic       out_stall;
    logic       sidetone_on;
    logic       record_valid;
    logic [7:0] record_code;
    logic       iambic_active;

    // keyer model state
    t_phase     k_phase;
    logic [1:0] k_left;
    logic       k_dah;
    logic [6:0] k_space;
    logic       k_counting;
    logic       k_iambic;
    logic       k_swap;

    t_result    keyed_q[$];
    int         mismatches;
    int         cycles;
    int         holds_asked;
    int         holds_done;
    logic       tx_gaps;
    logic       rx_gaps;

    iambic_keyer_recorder dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_paddle_a_pressed (paddle_a),
        .i_paddle_b_pressed (paddle_b),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_sidetone_on      (sidetone_on),
        .o_record_valid     (record_valid),
        .o_record_code      (record_code),
        .o_iambic_active    (iambic_active)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // run watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results pending", $time, keyed_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // model: load an element and its mark length
    function automatic void start_element(input logic dah);
        k_dah   = dah;
        k_left  = dah ? 2'd3 : 2'd1;
        k_phase = PH_MARK;
    endfunction

    // model: one sounding tick, gap follows the last one
    function automatic logic sound_mark();
        if (k_left <= 2'd1) begin
            k_left  = 2'd0;
            k_phase = PH_GAP;
        end else begin
            k_left = k_left - 2'd1;
        end
        return 1'b1;
    endfunction

    // model: one unit tick of the keyer and recorder
    function automatic t_result keyer_tick(input logic a, input logic b);
        t_result r;
        logic    dit;
        logic    dah;
        logic    idle_tick;
        dit       = k_swap ? b : a;
        dah       = k_swap ? a : b;
        r         = '0;
        idle_tick = 1'b0;
        case (k_phase)
            PH_MARK: begin
                r.sidetone_on = sound_mark();
            end
            PH_GAP: begin
                r.record_valid = 1'b1;
                r.record_code  = k_dah ? CODE_DAH : CODE_DIT;
                k_phase        = PH_DECIDE;
            end
            PH_DECIDE: begin
                // released paddle of the current element drops to idle on this tick
                if ((k_dah && !dah) || (!k_dah && !dit)) begin
                    k_phase    = PH_IDLE;
                    k_counting = 1'b1;
                    k_space    = '0;
                    idle_tick  = 1'b1;
                end else begin
                    k_iambic = dit && dah;
                    start_element((dit && dah) ? !k_dah : dah);
                    r.sidetone_on = sound_mark();
                end
            end
            default: begin
                idle_tick = 1'b1;
            end
        endcase
        if (idle_tick) begin
            if (dit || dah) begin
                if (k_counting) begin
                    r.record_valid = 1'b1;
                    r.record_code  = {SPACE_TAG, k_space};
                end
                k_space  = '0;
                k_iambic = dit && dah;
                start_element(!dit);
                r.sidetone_on = sound_mark();
            end else if (k_counting && k_space < SPACE_MAX) begin
                k_space = k_space + 7'd1;
            end
        end
        r.iambic_active = k_iambic;
        return r;
    endfunction

    // offer one paddle request after a random gap, predict on acceptance
    task automatic press_paddles(input logic a, input logic b);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        in_valid = 1'b1;
        paddle_a = a;
        paddle_b = b;
        do @(posedge clk); while (in_stall);
        keyed_q.push_back(keyer_tick(a, b));
    endtask

    // stop offering and wait until every result is out
    task automatic settle_keyer();
        @(negedge clk);
        in_valid = 1'b0;
        while (keyed_q.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // paddle orientation write, block idle
    task automatic set_swap(input logic swap);
        settle_keyer();
        cfg_we    = 1'b1;
        cfg_wdata = swap;
        @(negedge clk);
        cfg_we = 1'b0;
        k_swap = swap;
    endtask

    // result side: per-result stall, long hold on request
    initial begin : result_side
        int w;
        out_stall  = 1'b0;
        holds_done = 0;
        forever begin
            @(negedge clk);
            if (holds_done != holds_asked) begin
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                holds_done++;
            end
            w = rx_gaps ? $urandom_range(0, 7) : 0;
            if (w > 0) begin
                out_stall = 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // compare each taken result with the oldest prediction
    always @(posedge clk) begin : check_keyed
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (keyed_q.size() == 0) begin
                $display("%0t result with no request pending: tone %b valid %b code %h iambic %b",
                         $time, sidetone_on, record_valid, record_code, iambic_active);
                mismatches++;
            end else begin
                want = keyed_q.pop_front();
                if (sidetone_on !== want.sidetone_on) begin
                    $display("%0t sidetone_on expected %b actual %b",
                             $time, want.sidetone_on, sidetone_on);
                    mismatches++;
                end
                if (record_valid !== want.record_valid) begin
                    $display("%0t record_valid expected %b actual %b",
                             $time, want.record_valid, record_valid);
                    mismatches++;
                end
                if (record_code !== want.record_code) begin
                    $display("%0t record_code expected %h actual %h",
                             $time, want.record_code, record_code);
                    mismatches++;
                end
                if (iambic_active !== want.iambic_active) begin
                    $display("%0t iambic_active expected %b actual %b",
                             $time, want.iambic_active, iambic_active);
                    mismatches++;
                end
            end
        end
    end

    // dit, dah, squeeze from idle, repeat, alternation, space codes
    task automatic test_single_elements();
        logic [1:0] seq[$];
        set_swap(1'b0);
        seq = '{2'b10, 2'b00, 2'b00, 2'b00,
                2'b01, 2'b00, 2'b00, 2'b00, 2'b01,
                2'b11, 2'b11, 2'b11, 2'b11,
                2'b10, 2'b01, 2'b00, 2'b00, 2'b00, 2'b00};
        foreach (seq[i]) press_paddles(seq[i][1], seq[i][0]);
    endtask

    // swapped orientation, both from idle picks the dit paddle
    task automatic test_swapped_paddles();
        logic [1:0] seq[$];
        set_swap(1'b1);
        seq = '{2'b11, 2'b00, 2'b00, 2'b00, 2'b10, 2'b00, 2'b00, 2'b00};
        foreach (seq[i]) press_paddles(seq[i][1], seq[i][0]);
    endtask

    // held paddles, squeezes, silences (some past saturation) and noise
    task automatic key_random(input int n_items);
        int   sent;
        int   kind;
        int   len;
        logic a;
        logic b;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 12);
            a    = 1'b0;
            b    = 1'b0;
            case (kind)
                0, 1: a = 1'b1;
                2, 3: b = 1'b1;
                4, 5: begin
                    a = 1'b1;
                    b = 1'b1;
                end
                7: begin
                    if ($urandom_range(0, 3) == 0) len = $urandom_range(128, 140);
                end
                default: ;
            endcase
            repeat (len) begin
                if (kind >= 8) {a, b} = 2'($urandom_range(0, 3));
                press_paddles(a, b);
                sent++;
            end
        end
    endtask

    // both orientations, with and without idling on both sides
    task automatic test_random_keying();
        set_swap(1'b0);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        key_random(330);
        set_swap(1'b1);
        key_random(330);
        set_swap(1'b1);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        key_random(330);
        set_swap(1'b0);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        key_random(300);
    endtask

    // result side holds off while requests keep coming
    task automatic test_full_backpressure();
        settle_keyer();
        tx_gaps = 1'b0;
        holds_asked++;
        key_random(50);
        tx_gaps = 1'b1;
    endtask

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        paddle_a    = 1'b0;
        paddle_b    = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b0;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        mismatches  = 0;
        cycles      = 0;
        holds_asked = 0;
        k_phase     = PH_IDLE;
        k_left      = '0;
        k_dah       = 1'b0;
        k_space     = '0;
        k_counting  = 1'b0;
        k_iambic    = 1'b0;
        k_swap      = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_single_elements();
        test_swapped_paddles();
        test_random_keying();
        test_full_backpressure();
        settle_keyer();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
